FILE: design/vslerp_pkg.sv
// Shared types, constants and the arctangent table of the vector slerp unit.
`timescale 1ns / 1ps

package vslerp_pkg;

   // CORDIC datapath width and step count
   localparam int CW           = 34;
   localparam int CORDIC_STEPS = 30;

   // Q30 angle and scale constants, with the Q16 fraction one, Q14 unit and Q60 one
   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
   localparam logic [30:0] ONE_Q30     = 31'd1073741824;
   localparam logic [30:0] ANGLE_EPS   = 31'd1074;
   localparam logic [16:0] FRAC_ONE    = 17'd65536;
   localparam logic [16:0] UNIT_Q14    = 17'd16384;
   localparam logic [61:0] SQ_ONE_Q60  = 62'h1000_0000_0000_0000;

   // Arctangent of 2^-i in Q30
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'h3243F6A8;
         5'd1:  val = 32'h1DAC6705;
         5'd2:  val = 32'h0FADBAFC;
         5'd3:  val = 32'h07F56EA6;
         5'd4:  val = 32'h03FEAB76;
         5'd5:  val = 32'h01FFD55B;
         5'd6:  val = 32'h00FFFAAA;
         5'd7:  val = 32'h007FFF55;
         5'd8:  val = 32'h003FFFEA;
         5'd9:  val = 32'h001FFFFD;
         5'd10: val = 32'h000FFFFF;
         5'd11: val = 32'h0007FFFF;
         5'd12: val = 32'h0003FFFF;
         5'd13: val = 32'h0001FFFF;
         5'd14: val = 32'h0000FFFF;
         5'd15: val = 32'h00007FFF;
         5'd16: val = 32'h00003FFF;
         5'd17: val = 32'h00001FFF;
         5'd18: val = 32'h00000FFF;
         5'd19: val = 32'h000007FF;
         5'd20: val = 32'h000003FF;
         5'd21: val = 32'h000001FF;
         5'd22: val = 32'h000000FF;
         5'd23: val = 32'h0000007F;
         5'd24: val = 32'h0000003F;
         5'd25: val = 32'h0000001F;
         5'd26: val = 32'h0000000F;
         5'd27: val = 32'h00000008;
         5'd28: val = 32'h00000004;
         5'd29: val = 32'h00000002;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

   // Sideband through the input length square roots
   typedef struct packed {
      logic [2:0][15:0] a;
      logic [2:0][15:0] b;
      logic [16:0]      frac;
   } vec_side_type;

   // Sideband through the normalizing dividers
   typedef struct packed {
      logic [5:0]  neg;
      logic        zero_a;
      logic        zero_b;
      logic [16:0] frac;
   } div_side_type;

   // Sideband through the sin(omega) square root
   typedef struct packed {
      logic [5:0][31:0] n;
      logic [16:0]      frac;
      logic             d_neg;
      logic [30:0]      d_mag;
   } root_side_type;

   // Sideband through the angle CORDIC
   typedef struct packed {
      logic [5:0][31:0] n;
      logic [16:0]      frac;
      logic             d_neg;
   } cord_side_type;

   // Sideband through the sine CORDICs
   typedef struct packed {
      logic [5:0][31:0] n;
      logic             special;
      logic             degen;
      logic [2:0][15:0] ua;
   } sine_side_type;

   // Sideband through the result length square root
   typedef struct packed {
      logic [2:0]       r_neg;
      logic [2:0][32:0] r_mag;
      logic             special;
      logic             degen;
      logic [2:0][15:0] ua;
   } fin_side_type;

   // Sideband through the output dividers
   typedef struct packed {
      logic [2:0]       r_neg;
      logic             len_zero;
      logic             special;
      logic             degen;
      logic [2:0][15:0] ua;
   } post_side_type;

endpackage

FILE: design/vslerp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module vslerp_sqrt #(
   parameter int IN_W   = 48,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     in_value,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int RW = IN_W / 2;
   localparam int NS = RW;

   logic              valid_ff [0:NS-1];
   logic [RW-1:0]     root_ff  [0:NS-1];
   logic [SIDE_W-1:0] side_ff  [0:NS-1];
   logic [RW+1:0]     rem_ff   [0:NS-2];
   logic [IN_W-1:0]   rest_ff  [0:NS-2];

   genvar i;
   generate
      for (i = 0; i < NS; i++) begin : g_stage
         logic              pv;
         logic [RW-1:0]     proot;
         logic [SIDE_W-1:0] pside;
         logic [RW+1:0]     prem;
         logic [IN_W-1:0]   prest;
         logic [RW+1:0]     cur;
         logic [RW+1:0]     trial;
         logic              ge;

         if (i == 0) begin : g_first
            assign pv    = in_valid;
            assign proot = '0;
            assign pside = in_side;
            assign prem  = '0;
            assign prest = in_value;
         end else begin : g_next
            assign pv    = valid_ff[i-1];
            assign proot = root_ff[i-1];
            assign pside = side_ff[i-1];
            assign prem  = rem_ff[i-1];
            assign prest = rest_ff[i-1];
         end

         // bring down the next two bits and try the next root bit
         assign cur   = {prem[RW-1:0], prest[IN_W-1 -: 2]};
         assign trial = {proot, 2'b01};
         assign ge    = (cur >= trial);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else begin
               valid_ff[i] <= pv;
            end
            root_ff[i] <= {proot[RW-2:0], ge};
            side_ff[i] <= pside;
         end

         if (i < NS - 1) begin : g_rem
            always_ff @(posedge clock) begin
               rem_ff[i]  <= ge ? (cur - trial) : cur;
               rest_ff[i] <= {prest[IN_W-3:0], 2'b00};
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

FILE: design/vslerp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module vslerp_div #(
   parameter int NUM_W  = 54,
   parameter int DEN_W  = 24,
   parameter int QUO_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   localparam int HI_W = NUM_W - QUO_W;

   logic              valid_ff [0:QUO_W-1];
   logic [QUO_W-1:0]  quo_ff   [0:QUO_W-1];
   logic [SIDE_W-1:0] side_ff  [0:QUO_W-1];
   logic [DEN_W:0]    rem_ff   [0:QUO_W-2];
   logic [QUO_W-1:0]  low_ff   [0:QUO_W-2];
   logic [DEN_W-1:0]  den_ff   [0:QUO_W-2];

   genvar i;
   generate
      for (i = 0; i < QUO_W; i++) begin : g_stage
         logic              pv;
         logic [QUO_W-1:0]  pquo;
         logic [SIDE_W-1:0] pside;
         logic [DEN_W:0]    prem;
         logic [QUO_W-1:0]  plow;
         logic [DEN_W-1:0]  pden;
         logic [DEN_W:0]    cur;
         logic              ge;

         if (i == 0) begin : g_first
            assign pv    = in_valid;
            assign pquo  = '0;
            assign pside = in_side;
            assign prem  = {{(DEN_W + 1 - HI_W){1'b0}}, in_num[NUM_W-1:QUO_W]};
            assign plow  = in_num[QUO_W-1:0];
            assign pden  = in_den;
         end else begin : g_next
            assign pv    = valid_ff[i-1];
            assign pquo  = quo_ff[i-1];
            assign pside = side_ff[i-1];
            assign prem  = rem_ff[i-1];
            assign plow  = low_ff[i-1];
            assign pden  = den_ff[i-1];
         end

         // shift in one numerator bit and subtract when it fits
         assign cur = {prem[DEN_W-1:0], plow[QUO_W-1]};
         assign ge  = (cur >= {1'b0, pden});

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else begin
               valid_ff[i] <= pv;
            end
            quo_ff[i]  <= {pquo[QUO_W-2:0], ge};
            side_ff[i] <= pside;
         end

         if (i < QUO_W - 1) begin : g_rem
            always_ff @(posedge clock) begin
               rem_ff[i] <= ge ? (cur - {1'b0, pden}) : cur;
               low_ff[i] <= {plow[QUO_W-2:0], 1'b0};
               den_ff[i] <= pden;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

FILE: design/vslerp_cordic.sv
// Pipelined CORDIC, vectoring (angle) or rotation (sine) mode, one step per stage.
`timescale 1ns / 1ps

module vslerp_cordic #(
   parameter int VECTORING = 0,
   parameter int SIDE_W    = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [vslerp_pkg::CW-1:0]   in_x,
   input  logic signed [vslerp_pkg::CW-1:0]   in_y,
   input  logic signed [vslerp_pkg::CW-1:0]   in_z,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic signed [vslerp_pkg::CW-1:0]   out_x,
   output logic signed [vslerp_pkg::CW-1:0]   out_y,
   output logic signed [vslerp_pkg::CW-1:0]   out_z,
   output logic [SIDE_W-1:0]                  out_side
);
   import vslerp_pkg::*;

   logic                 valid_ff [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] x_ff     [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] y_ff     [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] z_ff     [0:CORDIC_STEPS-1];
   logic [SIDE_W-1:0]    side_ff  [0:CORDIC_STEPS-1];

   genvar i;
   generate
      for (i = 0; i < CORDIC_STEPS; i++) begin : g_stage
         logic                 pv;
         logic signed [CW-1:0] px;
         logic signed [CW-1:0] py;
         logic signed [CW-1:0] pz;
         logic [SIDE_W-1:0]    pside;
         logic signed [CW-1:0] xs;
         logic signed [CW-1:0] ys;
         logic signed [CW-1:0] ang;
         logic                 neg;

         if (i == 0) begin : g_first
            assign pv    = in_valid;
            assign px    = in_x;
            assign py    = in_y;
            assign pz    = in_z;
            assign pside = in_side;
         end else begin : g_next
            assign pv    = valid_ff[i-1];
            assign px    = x_ff[i-1];
            assign py    = y_ff[i-1];
            assign pz    = z_ff[i-1];
            assign pside = side_ff[i-1];
         end

         assign xs  = px >>> i;
         assign ys  = py >>> i;
         assign ang = $signed({2'b00, atan_entry(5'(i))});
         // vectoring drives y to zero, rotation drives z to zero
         assign neg = (VECTORING != 0) ? (py > 0) : (pz < 0);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else begin
               valid_ff[i] <= pv;
            end
            if (neg) begin
               x_ff[i] <= px + ys;
               y_ff[i] <= py - xs;
               z_ff[i] <= pz + ang;
            end else begin
               x_ff[i] <= px - ys;
               y_ff[i] <= py + xs;
               z_ff[i] <= pz - ang;
            end
            side_ff[i] <= pside;
         end
      end
   endgenerate

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign out_x     = x_ff[CORDIC_STEPS-1];
   assign out_y     = y_ff[CORDIC_STEPS-1];
   assign out_z     = z_ff[CORDIC_STEPS-1];
   assign out_side  = side_ff[CORDIC_STEPS-1];

endmodule

FILE: design/vector_slerp_unit.sv
// Top level of the vector slerp unit: fully pipelined spherical interpolation.
//
// Usage:
//   Drive the two Q1.14 vectors and the Q0.16 fraction on the req_ ports and
//   raise start for one cycle per word. busy stays low: a new word is taken
//   on every clock edge at which start is high, so back-to-back words stream
//   in at one per cycle.
//   Each word yields exactly one result word on the rsp_ ports, shown for a
//   single cycle with rsp_valid high, in the order the words were taken.
//   The pipeline is a chain of bit-serial stages: input length roots (24),
//   normalizing dividers (32), sin(omega) root (31), angle CORDIC (30), sine
//   CORDICs (30), result length root (32) and output dividers (16), plus 16
//   registered capture, multiply, round and output stages.
//   Throughput is one word per cycle.
//   The receiver cannot stall: rsp_valid words must be taken when shown.
//   Synchronous reset empties the pipeline; words in flight are dropped.
`timescale 1ns / 1ps

module vector_slerp_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_first_x,
   input  logic signed [15:0] req_first_y,
   input  logic signed [15:0] req_first_z,
   input  logic signed [15:0] req_second_x,
   input  logic signed [15:0] req_second_y,
   input  logic signed [15:0] req_second_z,
   input  logic [16:0]        req_fraction,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_result_x,
   output logic signed [15:0] rsp_result_y,
   output logic signed [15:0] rsp_result_z,
   output logic               rsp_degenerate
);
   import vslerp_pkg::*;

   // never blocks: one word per cycle
   assign busy = 1'b0;

   // ---------------- s0: capture the input word, clamp the fraction to one
   logic             s0_valid_ff;
   logic [2:0][15:0] s0_a_ff;
   logic [2:0][15:0] s0_b_ff;
   logic [16:0]      s0_frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
      end
      s0_a_ff    <= {req_first_z, req_first_y, req_first_x};
      s0_b_ff    <= {req_second_z, req_second_y, req_second_x};
      s0_frac_ff <= (req_fraction > FRAC_ONE) ? FRAC_ONE : req_fraction;
   end

   // ---------------- s1: squared lengths
   logic         s1_valid_ff;
   logic [31:0]  s1_l2a_ff;
   logic [31:0]  s1_l2b_ff;
   vec_side_type s1_side_ff;
   logic [31:0]  s1_l2a_in;
   logic [31:0]  s1_l2b_in;

   always_comb begin
      s1_l2a_in = '0;
      s1_l2b_in = '0;
      for (int k = 0; k < 3; k++) begin
         s1_l2a_in = s1_l2a_in + 32'($signed(s0_a_ff[k]) * $signed(s0_a_ff[k]));
         s1_l2b_in = s1_l2b_in + 32'($signed(s0_b_ff[k]) * $signed(s0_b_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_l2a_ff       <= s1_l2a_in;
      s1_l2b_ff       <= s1_l2b_in;
      s1_side_ff.a    <= s0_a_ff;
      s1_side_ff.b    <= s0_b_ff;
      s1_side_ff.frac <= s0_frac_ff;
   end

   // ---------------- input vector lengths, Q22
   logic         sa_valid;
   logic [23:0]  sa_root;
   logic [23:0]  sb_root;
   vec_side_type sa_side;

   vslerp_sqrt #(.IN_W(48), .SIDE_W($bits(vec_side_type))) u_sqrt_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_value  ({s1_l2a_ff, 16'd0}),
      .in_side   (s1_side_ff),
      .out_valid (sa_valid),
      .out_root  (sa_root),
      .out_side  (sa_side)
   );

   vslerp_sqrt #(.IN_W(48), .SIDE_W(1)) u_sqrt_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_value  ({s1_l2b_ff, 16'd0}),
      .in_side   (1'b0),
      .out_valid (),
      .out_root  (sb_root),
      .out_side  ()
   );

   // ---------------- s2: normalizing numerators
   logic             s2_valid_ff;
   logic [5:0][53:0] s2_num_ff;
   logic [1:0][23:0] s2_den_ff;
   div_side_type     s2_side_ff;
   logic [5:0][53:0] s2_num_in;
   logic [5:0]       s2_neg_in;
   logic [5:0][15:0] s2_comp;
   logic [15:0]      s2_mag;
   logic [23:0]      s2_len;

   always_comb begin
      s2_comp   = {sa_side.b, sa_side.a};
      s2_num_in = '0;
      s2_neg_in = '0;
      for (int k = 0; k < 6; k++) begin
         s2_len       = (k < 3) ? sa_root : sb_root;
         s2_neg_in[k] = s2_comp[k][15];
         s2_mag       = s2_comp[k][15] ? (16'd0 - s2_comp[k]) : s2_comp[k];
         s2_num_in[k] = {s2_mag, 38'd0} + {31'd0, s2_len[23:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= sa_valid;
      end
      s2_num_ff         <= s2_num_in;
      s2_den_ff         <= {sb_root, sa_root};
      s2_side_ff.neg    <= s2_neg_in;
      s2_side_ff.zero_a <= (sa_root == 24'd0);
      s2_side_ff.zero_b <= (sb_root == 24'd0);
      s2_side_ff.frac   <= sa_side.frac;
   end

   // ---------------- normalizing dividers, Q30 quotients
   logic             dv_valid;
   logic [5:0][31:0] dv_quo;
   div_side_type     dv_side;

   genvar g;
   generate
      for (g = 0; g < 6; g++) begin : g_ndiv
         if (g == 0) begin : g_lead
            vslerp_div #(.NUM_W(54), .DEN_W(24), .QUO_W(32),
                         .SIDE_W($bits(div_side_type))) u_div (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (s2_valid_ff),
               .in_num    (s2_num_ff[g]),
               .in_den    (s2_den_ff[g / 3]),
               .in_side   (s2_side_ff),
               .out_valid (dv_valid),
               .out_quo   (dv_quo[g]),
               .out_side  (dv_side)
            );
         end else begin : g_rest
            vslerp_div #(.NUM_W(54), .DEN_W(24), .QUO_W(32), .SIDE_W(1)) u_div (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (s2_valid_ff),
               .in_num    (s2_num_ff[g]),
               .in_den    (s2_den_ff[g / 3]),
               .in_side   (1'b0),
               .out_valid (),
               .out_quo   (dv_quo[g]),
               .out_side  ()
            );
         end
      end
   endgenerate

   // ---------------- s3: signed unit components
   logic             s3_valid_ff;
   logic [5:0][31:0] s3_n_ff;
   logic [16:0]      s3_frac_ff;
   logic [5:0][31:0] s3_n_in;
   logic             s3_zero;

   always_comb begin
      s3_n_in = '0;
      for (int k = 0; k < 6; k++) begin
         s3_zero = (k < 3) ? dv_side.zero_a : dv_side.zero_b;
         if (s3_zero) begin
            s3_n_in[k] = '0;
         end else if (dv_side.neg[k]) begin
            s3_n_in[k] = 32'd0 - dv_quo[k];
         end else begin
            s3_n_in[k] = dv_quo[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= dv_valid;
      end
      s3_n_ff    <= s3_n_in;
      s3_frac_ff <= dv_side.frac;
   end

   // ---------------- s4: dot product terms
   logic             s4_valid_ff;
   logic [2:0][63:0] s4_prod_ff;
   logic [5:0][31:0] s4_n_ff;
   logic [16:0]      s4_frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      for (int k = 0; k < 3; k++) begin
         s4_prod_ff[k] <= 64'($signed(s3_n_ff[k]) * $signed(s3_n_ff[k+3]));
      end
      s4_n_ff    <= s3_n_ff;
      s4_frac_ff <= s3_frac_ff;
   end

   // ---------------- s5: round and clamp the dot product
   logic               s5_valid_ff;
   logic               s5_d_neg_ff;
   logic [30:0]        s5_d_mag_ff;
   logic [5:0][31:0]   s5_n_ff;
   logic [16:0]        s5_frac_ff;
   logic signed [65:0] s5_sum;
   logic [65:0]        s5_mag;
   logic [35:0]        s5_rnd;
   logic [30:0]        s5_d_mag_in;

   always_comb begin
      s5_sum = 66'($signed(s4_prod_ff[0])) + 66'($signed(s4_prod_ff[1]))
             + 66'($signed(s4_prod_ff[2]));
      s5_mag = s5_sum[65] ? 66'(-s5_sum) : 66'(s5_sum);
      s5_rnd = 36'((s5_mag + 66'd536870912) >> 30);
      s5_d_mag_in = (s5_rnd > {5'd0, ONE_Q30}) ? ONE_Q30 : s5_rnd[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_d_neg_ff <= s5_sum[65] && (s5_rnd != 36'd0);
      s5_d_mag_ff <= s5_d_mag_in;
      s5_n_ff     <= s4_n_ff;
      s5_frac_ff  <= s4_frac_ff;
   end

   // ---------------- s6: d squared
   logic          s6_valid_ff;
   logic [61:0]   s6_dsq_ff;
   root_side_type s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_dsq_ff        <= 62'(s5_d_mag_ff * s5_d_mag_ff);
      s6_side_ff.n     <= s5_n_ff;
      s6_side_ff.frac  <= s5_frac_ff;
      s6_side_ff.d_neg <= s5_d_neg_ff;
      s6_side_ff.d_mag <= s5_d_mag_ff;
   end

   // ---------------- sin(omega) = sqrt(1 - d^2), Q30
   logic          ss_valid;
   logic [30:0]   ss_root;
   root_side_type ss_side;

   vslerp_sqrt #(.IN_W(62), .SIDE_W($bits(root_side_type))) u_sqrt_s (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_value  (SQ_ONE_Q60 - s6_dsq_ff),
      .in_side   (s6_side_ff),
      .out_valid (ss_valid),
      .out_root  (ss_root),
      .out_side  (ss_side)
   );

   // ---------------- angle between the unit vectors
   logic                 va_valid;
   logic signed [CW-1:0] va_z;
   cord_side_type        va_side_in;
   cord_side_type        va_side;

   assign va_side_in.n     = ss_side.n;
   assign va_side_in.frac  = ss_side.frac;
   assign va_side_in.d_neg = ss_side.d_neg;

   vslerp_cordic #(.VECTORING(1), .SIDE_W($bits(cord_side_type))) u_atan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ss_valid),
      .in_x      ($signed({3'b000, ss_side.d_mag})),
      .in_y      ($signed({3'b000, ss_root})),
      .in_z      ('0),
      .in_side   (va_side_in),
      .out_valid (va_valid),
      .out_x     (),
      .out_y     (),
      .out_z     (va_z),
      .out_side  (va_side)
   );

   // ---------------- s7: omega, special cases, rounded first vector
   logic             s7_valid_ff;
   logic [31:0]      s7_omega_ff;
   logic             s7_special_ff;
   logic             s7_degen_ff;
   logic [2:0][15:0] s7_ua_ff;
   logic [5:0][31:0] s7_n_ff;
   logic [16:0]      s7_frac_ff;
   logic [30:0]      s7_phi;
   logic [2:0][15:0] s7_ua_in;
   logic [31:0]      s7_nmag;
   logic [16:0]      s7_rq;
   logic [16:0]      s7_rs;

   always_comb begin
      if (va_z < 0) begin
         s7_phi = '0;
      end else if (va_z > $signed({2'b00, HALF_PI_Q30})) begin
         s7_phi = HALF_PI_Q30[30:0];
      end else begin
         s7_phi = va_z[30:0];
      end
      s7_ua_in = '0;
      for (int k = 0; k < 3; k++) begin
         s7_nmag = va_side.n[k][31] ? (32'd0 - va_side.n[k]) : va_side.n[k];
         s7_rq   = 17'(({1'b0, s7_nmag} + 33'd32768) >> 16);
         s7_rs   = (s7_rq > UNIT_Q14) ? UNIT_Q14 : s7_rq;
         s7_ua_in[k] = va_side.n[k][31] ? (16'd0 - s7_rs[15:0]) : s7_rs[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= va_valid;
      end
      s7_omega_ff   <= va_side.d_neg ? (PI_Q30 - {1'b0, s7_phi}) : {1'b0, s7_phi};
      s7_special_ff <= (s7_phi < ANGLE_EPS);
      s7_degen_ff   <= (s7_phi < ANGLE_EPS) && va_side.d_neg;
      s7_ua_ff      <= s7_ua_in;
      s7_n_ff       <= va_side.n;
      s7_frac_ff    <= va_side.frac;
   end

   // ---------------- s8: t * omega
   logic             s8_valid_ff;
   logic [31:0]      s8_tw_ff;
   logic [31:0]      s8_omega_ff;
   logic             s8_special_ff;
   logic             s8_degen_ff;
   logic [2:0][15:0] s8_ua_ff;
   logic [5:0][31:0] s8_n_ff;
   logic [48:0]      s8_tw_in;

   assign s8_tw_in = (s7_frac_ff * s7_omega_ff) + 49'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
      s8_tw_ff      <= s8_tw_in[47:16];
      s8_omega_ff   <= s7_omega_ff;
      s8_special_ff <= s7_special_ff;
      s8_degen_ff   <= s7_degen_ff;
      s8_ua_ff      <= s7_ua_ff;
      s8_n_ff       <= s7_n_ff;
   end

   // ---------------- s9: fold both angles into [0, pi/2]
   logic             s9_valid_ff;
   logic [1:0][31:0] s9_th_ff;
   sine_side_type    s9_side_ff;
   logic [31:0]      s9_th0;
   logic [31:0]      s9_th1;

   assign s9_th0 = s8_omega_ff - s8_tw_ff;
   assign s9_th1 = s8_tw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= s8_valid_ff;
      end
      s9_th_ff[0] <= (s9_th0 > HALF_PI_Q30) ? (PI_Q30 - s9_th0) : s9_th0;
      s9_th_ff[1] <= (s9_th1 > HALF_PI_Q30) ? (PI_Q30 - s9_th1) : s9_th1;
      s9_side_ff.n       <= s8_n_ff;
      s9_side_ff.special <= s8_special_ff;
      s9_side_ff.degen   <= s8_degen_ff;
      s9_side_ff.ua      <= s8_ua_ff;
   end

   // ---------------- weights sin((1-t)omega) and sin(t omega)
   logic                 sn_valid;
   logic signed [CW-1:0] sn_c0;
   logic signed [CW-1:0] sn_c1;
   sine_side_type        sn_side;

   vslerp_cordic #(.VECTORING(0), .SIDE_W($bits(sine_side_type))) u_sin0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s9_valid_ff),
      .in_x      ($signed({2'b00, CORDIC_GAIN})),
      .in_y      ('0),
      .in_z      ($signed({2'b00, s9_th_ff[0]})),
      .in_side   (s9_side_ff),
      .out_valid (sn_valid),
      .out_x     (),
      .out_y     (sn_c0),
      .out_z     (),
      .out_side  (sn_side)
   );

   vslerp_cordic #(.VECTORING(0), .SIDE_W(1)) u_sin1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s9_valid_ff),
      .in_x      ($signed({2'b00, CORDIC_GAIN})),
      .in_y      ('0),
      .in_z      ($signed({2'b00, s9_th_ff[1]})),
      .in_side   (1'b0),
      .out_valid (),
      .out_x     (),
      .out_y     (sn_c1),
      .out_z     (),
      .out_side  ()
   );

   // ---------------- s10: weighted components
   logic             s10_valid_ff;
   logic [5:0][65:0] s10_prod_ff;
   logic             s10_special_ff;
   logic             s10_degen_ff;
   logic [2:0][15:0] s10_ua_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else begin
         s10_valid_ff <= sn_valid;
      end
      for (int k = 0; k < 3; k++) begin
         s10_prod_ff[k]   <= 66'(sn_c0 * $signed(sn_side.n[k]));
         s10_prod_ff[k+3] <= 66'(sn_c1 * $signed(sn_side.n[k+3]));
      end
      s10_special_ff <= sn_side.special;
      s10_degen_ff   <= sn_side.degen;
      s10_ua_ff      <= sn_side.ua;
   end

   // ---------------- s11: round the sum to Q30
   logic               s11_valid_ff;
   logic [2:0]         s11_neg_ff;
   logic [2:0][32:0]   s11_mag_ff;
   logic               s11_special_ff;
   logic               s11_degen_ff;
   logic [2:0][15:0]   s11_ua_ff;
   logic signed [66:0] s11_sum;
   logic [66:0]        s11_abs;
   logic [2:0]         s11_neg_in;
   logic [2:0][32:0]   s11_mag_in;

   always_comb begin
      s11_neg_in = '0;
      s11_mag_in = '0;
      for (int k = 0; k < 3; k++) begin
         s11_sum = 67'($signed(s10_prod_ff[k])) + 67'($signed(s10_prod_ff[k+3]));
         s11_abs = s11_sum[66] ? 67'(-s11_sum) : 67'(s11_sum);
         s11_neg_in[k] = s11_sum[66];
         s11_mag_in[k] = 33'((s11_abs + 67'd536870912) >> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else begin
         s11_valid_ff <= s10_valid_ff;
      end
      s11_neg_ff     <= s11_neg_in;
      s11_mag_ff     <= s11_mag_in;
      s11_special_ff <= s10_special_ff;
      s11_degen_ff   <= s10_degen_ff;
      s11_ua_ff      <= s10_ua_ff;
   end

   // ---------------- s12: squares of the sum
   logic             s12_valid_ff;
   logic [2:0][63:0] s12_sq_ff;
   fin_side_type     s12_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_valid_ff <= 1'b0;
      end else begin
         s12_valid_ff <= s11_valid_ff;
      end
      for (int k = 0; k < 3; k++) begin
         s12_sq_ff[k] <= 64'(s11_mag_ff[k] * s11_mag_ff[k]);
      end
      s12_side_ff.r_neg   <= s11_neg_ff;
      s12_side_ff.r_mag   <= s11_mag_ff;
      s12_side_ff.special <= s11_special_ff;
      s12_side_ff.degen   <= s11_degen_ff;
      s12_side_ff.ua      <= s11_ua_ff;
   end

   // ---------------- s13: squared length, wraps at 64 bits
   logic         s13_valid_ff;
   logic [63:0]  s13_l2_ff;
   fin_side_type s13_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_valid_ff <= 1'b0;
      end else begin
         s13_valid_ff <= s12_valid_ff;
      end
      s13_l2_ff   <= s12_sq_ff[0] + s12_sq_ff[1] + s12_sq_ff[2];
      s13_side_ff <= s12_side_ff;
   end

   // ---------------- result length
   logic         sr_valid;
   logic [31:0]  sr_len;
   fin_side_type sr_side;

   vslerp_sqrt #(.IN_W(64), .SIDE_W($bits(fin_side_type))) u_sqrt_r (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s13_valid_ff),
      .in_value  (s13_l2_ff),
      .in_side   (s13_side_ff),
      .out_valid (sr_valid),
      .out_root  (sr_len),
      .out_side  (sr_side)
   );

   // ---------------- s14: output numerators
   logic             s14_valid_ff;
   logic [2:0][47:0] s14_num_ff;
   logic [31:0]      s14_den_ff;
   post_side_type    s14_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s14_valid_ff <= 1'b0;
      end else begin
         s14_valid_ff <= sr_valid;
      end
      for (int k = 0; k < 3; k++) begin
         s14_num_ff[k] <= {1'b0, sr_side.r_mag[k], 14'd0} + {17'd0, sr_len[31:1]};
      end
      s14_den_ff           <= sr_len;
      s14_side_ff.r_neg    <= sr_side.r_neg;
      s14_side_ff.len_zero <= (sr_len == 32'd0);
      s14_side_ff.special  <= sr_side.special;
      s14_side_ff.degen    <= sr_side.degen;
      s14_side_ff.ua       <= sr_side.ua;
   end

   // ---------------- output dividers, Q14
   logic             od_valid;
   logic [2:0][15:0] od_quo;
   post_side_type    od_side;

   generate
      for (g = 0; g < 3; g++) begin : g_odiv
         if (g == 0) begin : g_lead
            vslerp_div #(.NUM_W(48), .DEN_W(32), .QUO_W(16),
                         .SIDE_W($bits(post_side_type))) u_div (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (s14_valid_ff),
               .in_num    (s14_num_ff[g]),
               .in_den    (s14_den_ff),
               .in_side   (s14_side_ff),
               .out_valid (od_valid),
               .out_quo   (od_quo[g]),
               .out_side  (od_side)
            );
         end else begin : g_rest
            vslerp_div #(.NUM_W(48), .DEN_W(32), .QUO_W(16), .SIDE_W(1)) u_div (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (s14_valid_ff),
               .in_num    (s14_num_ff[g]),
               .in_den    (s14_den_ff),
               .in_side   (1'b0),
               .out_valid (),
               .out_quo   (od_quo[g]),
               .out_side  ()
            );
         end
      end
   endgenerate

   // ---------------- output word: saturate, sign, pick the special path
   logic             rsp_valid_ff;
   logic [2:0][15:0] rsp_res_ff;
   logic             rsp_degen_ff;
   logic [2:0][15:0] rsp_res_in;
   logic [15:0]      out_sat;

   always_comb begin
      rsp_res_in = '0;
      for (int k = 0; k < 3; k++) begin
         out_sat = (od_quo[k] > UNIT_Q14[15:0]) ? UNIT_Q14[15:0] : od_quo[k];
         if (od_side.special) begin
            rsp_res_in[k] = od_side.ua[k];
         end else if (od_side.len_zero) begin
            rsp_res_in[k] = '0;
         end else if (od_side.r_neg[k]) begin
            rsp_res_in[k] = 16'd0 - out_sat;
         end else begin
            rsp_res_in[k] = out_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= od_valid;
      end
      rsp_res_ff   <= rsp_res_in;
      rsp_degen_ff <= od_side.special & od_side.degen;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_x   = rsp_res_ff[0];
   assign rsp_result_y   = rsp_res_ff[1];
   assign rsp_result_z   = rsp_res_ff[2];
   assign rsp_degenerate = rsp_degen_ff;

endmodule

FILE: design/vslerp_checker.sv
// Port-level checks for the vector slerp unit, bound to the top level.
`timescale 1ns / 1ps

module vslerp_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [15:0] rsp_result_x,
   input logic signed [15:0] rsp_result_y,
   input logic signed [15:0] rsp_result_z,
   input logic               rsp_degenerate
);

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // the unit never pushes back on the requester
   assert property (@(posedge clock) disable iff (reset) start |-> !busy)
      else $error("start refused");

   // every component stays within the unit range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_x <= 16'sd16384 && rsp_result_x >= -16'sd16384 &&
                     rsp_result_y <= 16'sd16384 && rsp_result_y >= -16'sd16384 &&
                     rsp_result_z <= 16'sd16384 && rsp_result_z >= -16'sd16384))
      else $error("result component out of range");

   // a degenerate word carries the unit first vector, so one component is large
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_result_x >= 16'sd8192 || rsp_result_x <= -16'sd8192 ||
          rsp_result_y >= 16'sd8192 || rsp_result_y <= -16'sd8192 ||
          rsp_result_z >= 16'sd8192 || rsp_result_z <= -16'sd8192))
      else $error("degenerate word without a unit vector");

endmodule

bind vector_slerp_unit vslerp_checker u_checker (.*);
